// ===== rtl/bpws_pkg.sv =====
// bpws_pkg: shared types and constants of the bev pool weighted sum unit
// depends on nothing; imported by every module of the block
package bpws_pkg;

    localparam int ACC_W     = 48;
    localparam int PROD_W    = 33;
    localparam int NUM_CH_W  = 7;
    localparam int CH_W      = 6;
    localparam int CELL_W    = 20;
    localparam int SUM_W     = 24;
    localparam int Q_DEPTH   = 4;
    localparam int RQ_DEPTH  = 4;
    localparam int RND_SHIFT = 15;

    localparam logic [NUM_CH_W-1:0] NUM_CH_RESET = 7'd64;
    localparam logic [SUM_W-1:0]    OUT_MAX      = 24'h7FFFFF;
    localparam logic [SUM_W-1:0]    OUT_MIN      = 24'h800000;

    typedef struct packed {
        logic [15:0]        depth_weight;
        logic signed [15:0] feature;
        logic [CH_W-1:0]    channel;
        logic [CELL_W-1:0]  bev_cell;
        logic               last_point;
    } item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] pooled_sum;
        logic [CH_W-1:0]         channel_out;
        logic [CELL_W-1:0]       cell_out;
        logic                    saturated;
    } result_t;

endpackage

// ===== rtl/bpws_front.sv =====
// bpws_front: channel count register, drop of inactive channels, item queue
// depends on bpws_pkg
module bpws_front
    import bpws_pkg::*;
#(
    parameter int MAX_CHANNELS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [NUM_CH_W-1:0] cfg_data,
    input  logic                push,
    output logic                full,
    input  item_t               in_item,
    input  logic                deq,
    output logic                q_valid,
    output item_t               q_item
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [NUM_CH_W-1:0] num_ch_reg;
    item_t               q_mem [Q_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                active;
    logic                wr_en;
    logic                rd_en;

    assign cfg_ready = 1'b1;
    assign full      = (cnt_reg == CNT_W'(Q_DEPTH));
    assign q_valid   = (cnt_reg != '0);
    assign q_item    = q_mem[rd_ptr_reg];

    assign active = ({1'b0, in_item.channel} < num_ch_reg)
                 && (32'(in_item.channel) < 32'(MAX_CHANNELS));
    assign wr_en  = push && !full && active;
    assign rd_en  = deq && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ch_reg <= NUM_CH_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                num_ch_reg <= cfg_data;
            end
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/bpws_accum.sv =====
// bpws_accum: per-channel accumulator memory, multiply-accumulate and output rounding
// depends on bpws_pkg
module bpws_accum
    import bpws_pkg::*;
#(
    parameter int MAX_CHANNELS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        issue,
    input  item_t       item,
    output logic [1:0]  pend_cnt,
    output logic        res_valid,
    output result_t     res
);

    localparam int ACC_DEPTH = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;
    localparam int IDX_W     = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    localparam int RND_W     = ACC_W + 1 - RND_SHIFT;

    logic [ACC_W-1:0]        acc_mem [ACC_DEPTH];
    logic [ACC_DEPTH-1:0]    vld_reg;
    logic [IDX_W-1:0]        issue_idx;

    logic                    s1_valid_reg;
    logic                    s1_last_reg;
    logic [CH_W-1:0]         s1_ch_reg;
    logic [CELL_W-1:0]       s1_cell_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;
    logic [ACC_W-1:0]        rd_data_reg;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        s1_idx;

    logic                    byp_valid_reg;
    logic [IDX_W-1:0]        byp_idx_reg;
    logic [ACC_W-1:0]        byp_data_reg;

    logic [ACC_W-1:0]        acc_base;
    logic [ACC_W-1:0]        acc_sum;

    logic                    s2_valid_reg;
    logic [ACC_W-1:0]        s2_sum_reg;
    logic [CH_W-1:0]         s2_ch_reg;
    logic [CELL_W-1:0]       s2_cell_reg;

    logic signed [ACC_W:0]   rnd_full;
    logic [RND_W-1:0]        rnd_q;
    logic                    sat_hi;
    logic                    sat_lo;

    assign issue_idx = item.channel[IDX_W-1:0];
    assign s1_idx    = s1_ch_reg[IDX_W-1:0];

    // bypass covers the write that the registered read missed
    always_comb
    begin
        if (byp_valid_reg && (byp_idx_reg == s1_idx))
        begin
            acc_base = byp_data_reg;
        end
        else if (rd_vld_reg)
        begin
            acc_base = rd_data_reg;
        end
        else
        begin
            acc_base = '0;
        end
        acc_sum = acc_base + {{(ACC_W-PROD_W){s1_prod_reg[PROD_W-1]}}, s1_prod_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= issue;
            byp_valid_reg <= s1_valid_reg;
            s2_valid_reg  <= s1_valid_reg && s1_last_reg;
            if (s1_valid_reg)
            begin
                vld_reg[s1_idx] <= !s1_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_last_reg <= item.last_point;
            s1_ch_reg   <= item.channel;
            s1_cell_reg <= item.bev_cell;
            s1_prod_reg <= $signed({1'b0, item.depth_weight}) * item.feature;
            rd_data_reg <= acc_mem[issue_idx];
            rd_vld_reg  <= vld_reg[issue_idx];
        end
        if (s1_valid_reg)
        begin
            acc_mem[s1_idx] <= acc_sum;
        end
        byp_idx_reg  <= s1_idx;
        byp_data_reg <= s1_last_reg ? '0 : acc_sum;
        s2_sum_reg   <= acc_sum;
        s2_ch_reg    <= s1_ch_reg;
        s2_cell_reg  <= s1_cell_reg;
    end

    // round half up, then clip to the output range
    always_comb
    begin
        rnd_full = $signed({s2_sum_reg[ACC_W-1], s2_sum_reg}) + (ACC_W+1)'(16384);
        rnd_q    = rnd_full[ACC_W:RND_SHIFT];
        sat_hi   = !rnd_q[RND_W-1] && (rnd_q[RND_W-2:SUM_W-1] != '0);
        sat_lo   = rnd_q[RND_W-1] && (rnd_q[RND_W-2:SUM_W-1] != '1);
        res.channel_out = s2_ch_reg;
        res.cell_out    = s2_cell_reg;
        res.saturated   = sat_hi || sat_lo;
        if (sat_hi)
        begin
            res.pooled_sum = OUT_MAX;
        end
        else if (sat_lo)
        begin
            res.pooled_sum = OUT_MIN;
        end
        else
        begin
            res.pooled_sum = rnd_q[SUM_W-1:0];
        end
    end

    assign res_valid = s2_valid_reg;
    assign pend_cnt  = {1'b0, s1_valid_reg && s1_last_reg} + {1'b0, s2_valid_reg};

endmodule

// ===== rtl/bpws_result_queue.sv =====
// bpws_result_queue: small queue of finished sums toward the consumer
// depends on bpws_pkg
module bpws_result_queue
    import bpws_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  result_t                      wr_data,
    input  logic                         pop,
    output logic                         empty,
    output result_t                      rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             rd_en;

    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rd_ptr_reg];
    assign count   = cnt_reg;
    assign rd_en   = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/bev_pool_weighted_sum_unit.sv =====
// bev_pool_weighted_sum_unit: top level of the pillar pooling weighted sum
// depends on bpws_pkg, bpws_front, bpws_accum, bpws_result_queue
//
// Takes one gathered element per cycle while full is low, and adds
// depth_weight * feature into a 48-bit accumulator per channel; on an
// interval's last point it emits the sum rounded to Q16.8, clipped to 24
// bits, and clears that channel. Elements with channel >= num_channels are
// dropped. Throughput is one beat per clock while issue is not held back by
// result queue space; a result passes the input queue, the accumulator
// memory read and the add, and is rounded in front of the result queue. The
// 64 x 48 accumulator memory is read once and written once per cycle, and a
// one-entry bypass lets the same channel arrive on consecutive beats.
// Accumulators read as zero after reset through per-entry valid bits, so no clearing pass is needed.
module bev_pool_weighted_sum_unit
    import bpws_pkg::*;
#(
    parameter int MAX_CHANNELS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [NUM_CH_W-1:0]     cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [15:0]             depth_weight,
    input  logic signed [15:0]      feature,
    input  logic [CH_W-1:0]         channel,
    input  logic [CELL_W-1:0]       bev_cell,
    input  logic                    last_point,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [SUM_W-1:0] pooled_sum,
    output logic [CH_W-1:0]         channel_out,
    output logic [CELL_W-1:0]       cell_out,
    output logic                    saturated
);

    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    item_t               in_item;
    item_t               q_item;
    logic                q_valid;
    logic                issue;
    logic [1:0]          pend_cnt;
    logic                res_valid;
    result_t             res;
    result_t             out_res;
    logic [RQ_CNT_W-1:0] out_cnt;

    assign in_item.depth_weight = depth_weight;
    assign in_item.feature      = feature;
    assign in_item.channel      = channel;
    assign in_item.bev_cell     = bev_cell;
    assign in_item.last_point   = last_point;

    // only issue while the result queue can take every pending sum
    assign issue = q_valid
                && ((32'(out_cnt) + 32'(pend_cnt)) < 32'(RQ_DEPTH));

    bpws_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .deq       (issue),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    bpws_accum #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .item      (q_item),
        .pend_cnt  (pend_cnt),
        .res_valid (res_valid),
        .res       (res)
    );

    bpws_result_queue #(
        .DEPTH (RQ_DEPTH)
    ) u_result_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .pop     (pop),
        .empty   (empty),
        .rd_data (out_res),
        .count   (out_cnt)
    );

    assign pooled_sum  = out_res.pooled_sum;
    assign channel_out = out_res.channel_out;
    assign cell_out    = out_res.cell_out;
    assign saturated   = out_res.saturated;

endmodule

// ===== test/tb_bev_pool_weighted_sum_unit.sv =====
`timescale 1ns / 100ps
// tb_bev_pool_weighted_sum_unit: self-checking bench for the pillar pooling weighted sum unit
// depends on bpws_pkg and bev_pool_weighted_sum_unit; directed table, then random intervals
module tb_bev_pool_weighted_sum_unit;
    import bpws_pkg::*;

    typedef struct packed {
        logic              wr_cfg;
        logic [6:0]        chans;
        logic [15:0]       weight;
        logic [15:0]       feat;
        logic [5:0]        ch;
        logic [19:0]       cell_id;
        logic              last;
        logic              typed;
        logic [23:0]       sum;
        logic              sat;
    } dir_row_t;

    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{1'b0, 7'd0,   16'd32768, 16'h0100, 6'd0,  20'h00000, 1'b1, 1'b1, 24'd256,   1'b0},
        '{1'b0, 7'd0,   16'd65535, 16'h7FFF, 6'd63, 20'hFFFFF, 1'b1, 1'b1, 24'd65533, 1'b0},
        '{1'b0, 7'd0,   16'd65535, 16'h8000, 6'd1,  20'h5A5A5, 1'b1, 1'b1, 24'hFF0001, 1'b0},
        '{1'b0, 7'd0,   16'd0,     16'h8000, 6'd2,  20'hA5A5A, 1'b1, 1'b1, 24'd0,     1'b0},
        '{1'b0, 7'd0,   16'd16384, 16'h0001, 6'd3,  20'h00001, 1'b1, 1'b1, 24'd1,     1'b0},
        '{1'b0, 7'd0,   16'd16384, 16'hFFFF, 6'd3,  20'h00002, 1'b1, 1'b1, 24'd0,     1'b0},
        '{1'b0, 7'd0,   16'd16385, 16'hFFFF, 6'd3,  20'h00003, 1'b1, 1'b1, 24'hFFFFFF, 1'b0},
        '{1'b0, 7'd0,   16'd32768, 16'h0200, 6'd5,  20'h00010, 1'b0, 1'b0, 24'd0,     1'b0},
        '{1'b0, 7'd0,   16'd32768, 16'hFF00, 6'd5,  20'h00010, 1'b0, 1'b0, 24'd0,     1'b0},
        '{1'b0, 7'd0,   16'd32768, 16'h0001, 6'd5,  20'h00010, 1'b1, 1'b0, 24'd0,     1'b0},
        '{1'b0, 7'd0,   16'd40000, 16'h0100, 6'd6,  20'h00020, 1'b1, 1'b0, 24'd0,     1'b0},
        '{1'b1, 7'd4,   16'd32768, 16'h0064, 6'd4,  20'h00030, 1'b1, 1'b0, 24'd0,     1'b0},
        '{1'b0, 7'd0,   16'd32768, 16'hFF00, 6'd3,  20'h00031, 1'b1, 1'b0, 24'd0,     1'b0},
        '{1'b1, 7'd0,   16'd32768, 16'h0100, 6'd0,  20'h00040, 1'b1, 1'b0, 24'd0,     1'b0},
        '{1'b1, 7'd127, 16'd32768, 16'h0007, 6'd63, 20'h00050, 1'b1, 1'b1, 24'd7,     1'b0},
        '{1'b1, 7'd1,   16'd32768, 16'h0003, 6'd0,  20'h00060, 1'b0, 1'b0, 24'd0,     1'b0},
        '{1'b0, 7'd0,   16'd32768, 16'h0050, 6'd1,  20'h00061, 1'b1, 1'b0, 24'd0,     1'b0},
        '{1'b0, 7'd0,   16'd32768, 16'h0004, 6'd0,  20'h00062, 1'b1, 1'b0, 24'd0,     1'b0},
        '{1'b1, 7'd64,  16'd8000,  16'h1234, 6'd63, 20'h00070, 1'b0, 1'b0, 24'd0,     1'b0},
        '{1'b0, 7'd0,   16'd12345, 16'hEDCB, 6'd62, 20'h00071, 1'b1, 1'b0, 24'd0,     1'b0},
        '{1'b0, 7'd0,   16'd50000, 16'h0F0F, 6'd63, 20'h00072, 1'b1, 1'b0, 24'd0,     1'b0}
    };

    localparam int SETTING_COUNT = 7;
    localparam int SETTING_BEATS = 150;
    localparam int SETTLE_CYCLES = 12;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [NUM_CH_W-1:0]     cfg_data;
    logic                    push;
    logic                    full;
    item_t                   drive_item;
    logic                    empty;
    logic                    pop;
    logic signed [SUM_W-1:0] pooled_sum;
    logic [CH_W-1:0]         channel_out;
    logic [CELL_W-1:0]       cell_out;
    logic                    saturated;

    logic signed [ACC_W-1:0] chan_acc [64];
    logic [NUM_CH_W-1:0]     chan_count;
    result_t                 pending_sums [$];
    int                      errors;
    int                      active_beats;
    int                      send_idle_pct;
    int                      recv_stall_pct;
    logic                    typed_on;
    logic [SUM_W-1:0]        typed_sum;
    logic                    typed_sat;

    bev_pool_weighted_sum_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .depth_weight (drive_item.depth_weight),
        .feature      (drive_item.feature),
        .channel      (drive_item.channel),
        .bev_cell     (drive_item.bev_cell),
        .last_point   (drive_item.last_point),
        .empty        (empty),
        .pop          (pop),
        .pooled_sum   (pooled_sum),
        .channel_out  (channel_out),
        .cell_out     (cell_out),
        .saturated    (saturated)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic pool_step(input item_t it, output result_t res);
        logic signed [ACC_W-1:0] wide_w;
        logic signed [ACC_W-1:0] wide_f;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W:0]   rounded;
        res = '0;
        if ({1'b0, it.channel} >= chan_count)
            return 1'b0;
        wide_w = {32'd0, it.depth_weight};
        wide_f = {{32{it.feature[15]}}, it.feature};
        acc = chan_acc[it.channel] + wide_w * wide_f;
        chan_acc[it.channel] = acc;
        if (!it.last_point)
            return 1'b0;
        rounded = ($signed({acc[ACC_W-1], acc}) + 49'sd16384) >>> RND_SHIFT;
        chan_acc[it.channel] = '0;
        res.channel_out = it.channel;
        res.cell_out = it.bev_cell;
        if (rounded > 49'sd8388607)
        begin
            res.pooled_sum = OUT_MAX;
            res.saturated = 1'b1;
        end
        else if (rounded < -49'sd8388608)
        begin
            res.pooled_sum = OUT_MIN;
            res.saturated = 1'b1;
        end
        else
        begin
            res.pooled_sum = rounded[SUM_W-1:0];
        end
        return 1'b1;
    endfunction

    task automatic show_mismatch(input string field, input longint want, input longint got);
        errors++;
        $display("%0t %s: expected %0d actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : watch
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_sums.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected beat: expected none actual sum %0d ch %0d cell %0d",
                             $time, pooled_sum, channel_out, cell_out);
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (pooled_sum !== want.pooled_sum)
                        show_mismatch("pooled_sum", want.pooled_sum, pooled_sum);
                    if (channel_out !== want.channel_out)
                        show_mismatch("channel_out", want.channel_out, channel_out);
                    if (cell_out !== want.cell_out)
                        show_mismatch("cell_out", want.cell_out, cell_out);
                    if (saturated !== want.saturated)
                        show_mismatch("saturated", want.saturated, saturated);
                end
            end
            if (cfg_valid && cfg_ready)
                chan_count = cfg_data;
            if (push && !full)
            begin
                if (pool_step(drive_item, pred))
                begin
                    if (typed_on)
                    begin
                        pred.pooled_sum = typed_sum;
                        pred.saturated = typed_sat;
                    end
                    pending_sums.push_back(pred);
                end
            end
        end
    end

    // entered and left at a falling edge
    task automatic push_beat(input item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        drive_item <= it;
        if ({1'b0, it.channel} < chan_count)
            active_beats++;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_channels(input logic [NUM_CH_W-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 3))
            0, 1: return 16'($urandom_range(0, 32768));
            2: return 16'($urandom);
            default:
                case ($urandom_range(0, 2))
                    0: return 16'd0;
                    1: return 16'd32768;
                    default: return 16'd65535;
                endcase
        endcase
    endfunction

    function automatic logic [15:0] rand_feature();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic gen_interval();
        int          kind;
        int          len;
        int          eff;
        int          k;
        int          base;
        int          pts;
        int          i;
        int          j;
        logic        pos;
        logic [19:0] cell_id;
        item_t       it;
        eff = (chan_count > 7'd64) ? 64 : int'(chan_count);
        kind = $urandom_range(0, 99);
        cell_id = 20'($urandom);
        it.bev_cell = cell_id;
        if (kind < 55)
        begin
            it.channel = 6'($urandom_range(0, eff - 1));
            if ($urandom_range(0, 29) == 0)
            begin
                // long same-sign run to drive the sum past the output range
                len = $urandom_range(150, 200);
                pos = 1'($urandom_range(0, 1));
                for (i = 0; i < len; i++)
                begin
                    it.depth_weight = 16'($urandom_range(60000, 65535));
                    it.feature = pos ? 16'($urandom_range(30000, 32767))
                                     : 16'(-int'($urandom_range(30000, 32768)));
                    it.last_point = (i == len - 1);
                    push_beat(it);
                end
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++)
                begin
                    it.depth_weight = rand_weight();
                    it.feature = rand_feature();
                    it.last_point = (i == len - 1);
                    push_beat(it);
                end
            end
        end
        else if (kind < 80)
        begin
            k = $urandom_range(1, (eff < 4) ? eff : 4);
            base = $urandom_range(0, eff - k);
            pts = $urandom_range(1, 4);
            for (i = 0; i < pts; i++)
            begin
                it.depth_weight = rand_weight();
                for (j = 0; j < k; j++)
                begin
                    it.channel = 6'(base + j);
                    it.feature = rand_feature();
                    it.last_point = (i == pts - 1);
                    push_beat(it);
                end
            end
        end
        else if (kind < 92)
        begin
            // broken interval: stray channel, missing or early close
            len = $urandom_range(1, 5);
            it.channel = 6'($urandom_range(0, 63));
            for (i = 0; i < len; i++)
            begin
                it.depth_weight = rand_weight();
                it.feature = rand_feature();
                it.last_point = ($urandom_range(0, 3) == 0);
                push_beat(it);
            end
        end
        else
        begin
            it.depth_weight = 16'($urandom);
            it.feature = 16'($urandom);
            it.channel = 6'($urandom);
            it.last_point = 1'($urandom);
            push_beat(it);
        end
    endtask

    initial
    begin : stimulus
        logic [NUM_CH_W-1:0] cfg_plan [SETTING_COUNT];
        item_t               it;
        dir_row_t            r;
        int                  target;
        int                  n;
        int                  s;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        push = 1'b0;
        drive_item = '0;
        pop = 1'b0;
        typed_on = 1'b0;
        typed_sum = '0;
        typed_sat = 1'b0;
        errors = 0;
        active_beats = 0;
        send_idle_pct = 9;
        recv_stall_pct = 49;
        chan_count = NUM_CH_RESET;
        for (n = 0; n < 64; n++)
            chan_acc[n] = '0;
        cfg_plan = '{7'd64, 7'd127, 7'd1, 7'($urandom_range(2, 63)), 7'd0,
                     7'($urandom_range(1, 127)), 7'd64};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (n = 0; n < DIR_ROWS; n++)
        begin
            r = DIRECTED_ROWS[n];
            if (r.wr_cfg)
            begin
                wait_idle();
                set_channels(r.chans);
            end
            typed_on <= r.typed;
            typed_sum <= r.sum;
            typed_sat <= r.sat;
            it.depth_weight = r.weight;
            it.feature = r.feat;
            it.channel = r.ch;
            it.bev_cell = r.cell_id;
            it.last_point = r.last;
            push_beat(it);
        end
        typed_on <= 1'b0;

        for (s = 0; s < SETTING_COUNT; s++)
        begin
            if (s == 2)
            begin
                send_idle_pct = 49;
                recv_stall_pct = 9;
            end
            else if (s == 5)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            wait_idle();
            set_channels(cfg_plan[s]);
            if (cfg_plan[s] == 0)
            begin
                repeat (25) gen_interval();
            end
            else
            begin
                target = active_beats + SETTING_BEATS;
                while (active_beats < target)
                    gen_interval();
            end
        end

        push <= 1'b0;
        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("bev_pool_weighted_sum_unit: match");
        else
            $display("bev_pool_weighted_sum_unit: mismatch");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("bev_pool_weighted_sum_unit: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bpws_pkg.sv
rtl/bpws_front.sv
rtl/bpws_accum.sv
rtl/bpws_result_queue.sv
rtl/bev_pool_weighted_sum_unit.sv
test/tb_bev_pool_weighted_sum_unit.sv
